// ===== rtl/core/htc_pkg.sv =====
`default_nettype none
package htc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int MAX_POLY_DEF  = 9;
  localparam int DIST_W        = 34;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // plane order of the clipping passes
  localparam logic [2:0] PL_NEAR   = 3'd0;
  localparam logic [2:0] PL_FAR    = 3'd1;
  localparam logic [2:0] PL_LEFT   = 3'd2;
  localparam logic [2:0] PL_RIGHT  = 3'd3;
  localparam logic [2:0] PL_BOTTOM = 3'd4;
  localparam logic [2:0] PL_TOP    = 3'd5;

  // result status codes
  localparam logic [1:0] ST_KEEP   = 2'd0;
  localparam logic [1:0] ST_CLIP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // interpolated component order
  localparam logic [2:0] LC_X  = 3'd0;
  localparam logic [2:0] LC_Y  = 3'd1;
  localparam logic [2:0] LC_Z  = 3'd2;
  localparam logic [2:0] LC_W  = 3'd3;
  localparam logic [2:0] LC_B0 = 3'd4;
  localparam logic [2:0] LC_B1 = 3'd5;
  localparam logic [2:0] LC_B2 = 3'd6;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_w;
  } vertex_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic [16:0]        bary_first;
    logic [16:0]        bary_second;
    logic [16:0]        bary_third;
    logic [1:0]         status;
    logic [2:0]         outside_mask;
    logic               last;
  } result_t;

  typedef struct packed {
    vertex_t [2:0] v;
    logic [2:0]    mask;
  } tri_t;

  // queue status seen by the front end
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

  function automatic logic signed [DIST_W-1:0] sx(input logic signed [31:0] a);
    sx = $signed({{(DIST_W-32){a[31]}}, a});
  endfunction

  // signed distance of a point to one frustum plane
  function automatic logic signed [DIST_W-1:0] plane_dist(
    input logic signed [31:0] x, input logic signed [31:0] y,
    input logic signed [31:0] z, input logic signed [31:0] w,
    input logic [2:0] k);
    unique case (k)
      PL_NEAR:   plane_dist = sx(z) + sx(w);
      PL_FAR:    plane_dist = sx(w) - sx(z);
      PL_LEFT:   plane_dist = sx(x) + sx(w);
      PL_RIGHT:  plane_dist = sx(w) - sx(x);
      PL_BOTTOM: plane_dist = sx(y) + sx(w);
      PL_TOP:    plane_dist = sx(w) - sx(y);
      default:   plane_dist = sx(z) + sx(w);
    endcase
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] a);
    neg_sat = (a == 32'sh8000_0000) ? 32'sh7fff_ffff : -a;
  endfunction

  // w placed back on the plane after a crossing
  function automatic logic signed [31:0] forced_w(
    input logic signed [31:0] x, input logic signed [31:0] y,
    input logic signed [31:0] z, input logic [2:0] k);
    unique case (k)
      PL_NEAR:   forced_w = neg_sat(z);
      PL_FAR:    forced_w = z;
      PL_LEFT:   forced_w = neg_sat(x);
      PL_RIGHT:  forced_w = x;
      PL_BOTTOM: forced_w = neg_sat(y);
      PL_TOP:    forced_w = y;
      default:   forced_w = neg_sat(z);
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/htc_queue.sv =====
`default_nettype none
module htc_queue
  import htc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire tri_t   push_data,
  input  wire logic   pop,
  output qstat_t      stat,
  output tri_t        pop_data
);

  tri_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;

  assign stat.full  = (cnt == 2'd2);
  assign stat.valid = (cnt != 2'd0);
  assign pop_data   = slots[rp];

  // hold triangles between front and back
  always_ff @(posedge clk) begin
    if (push && !stat.full) begin
      slots[wp] <= push_data;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push && !stat.full) wp <= ~wp;
      if (pop && stat.valid) rp <= ~rp;
      unique case ({push && !stat.full, pop && stat.valid})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/htc_front.sv =====
`default_nettype none
module htc_front
  import htc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire vertex_t vertex,
  input  wire qstat_t  qstat,
  output logic         busy,
  output logic         push,
  output tri_t         push_data
);

  vertex_t    v0;
  vertex_t    v1;
  logic [1:0] fails;
  logic [1:0] cnt;
  logic       accept;
  logic       fail_in;

  assign busy   = qstat.full;
  assign accept = start && !busy;

  // test the incoming vertex against all six planes
  always_comb begin
    fail_in = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (plane_dist(vertex.pos_x, vertex.pos_y, vertex.pos_z, vertex.pos_w,
                     3'(k)) < 0) fail_in = 1'b1;
    end
  end

  assign push           = accept && (cnt == 2'd2);
  assign push_data.v[0] = v0;
  assign push_data.v[1] = v1;
  assign push_data.v[2] = vertex;
  assign push_data.mask = {fail_in, fails};

  // gather vertices until a triangle is complete
  always_ff @(posedge clk) begin
    if (accept && cnt == 2'd0) begin
      v0       <= vertex;
      fails[0] <= fail_in;
    end
    if (accept && cnt == 2'd1) begin
      v1       <= vertex;
      fails[1] <= fail_in;
    end
    if (rst) begin
      cnt <= 2'd0;
    end else if (accept) begin
      cnt <= (cnt == 2'd2) ? 2'd0 : cnt + 2'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/htc_back.sv =====
`default_nettype none
module htc_back
  import htc_pkg::*;
#(
  parameter int FRAC_BITS         = FRAC_BITS_DEF,
  parameter int MAX_POLY_VERTICES = MAX_POLY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire qstat_t qstat,
  input  wire tri_t  tri_in,
  output logic       pop,
  output logic       strobe,
  output result_t    result
);

  localparam int IW   = $clog2(MAX_POLY_VERTICES + 1);
  localparam int PW   = $clog2(MAX_POLY_VERTICES);
  localparam int NW   = DIST_W + 1 + FRAC_BITS;
  localparam int CW   = $clog2(FRAC_BITS + 1);
  localparam int PRW  = DIST_W + FRAC_BITS + 2;
  localparam logic signed [PRW-1:0] HALF = PRW'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic [2:0][16:0]   b;
  } poly_t;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_TRIV    = 16'h0002,
    S_LOAD    = 16'h0004,
    S_PREV_RD = 16'h0008,
    S_PREV_WT = 16'h0010,
    S_CUR_RD  = 16'h0020,
    S_CUR_EV  = 16'h0040,
    S_DIV     = 16'h0080,
    S_MUL     = 16'h0100,
    S_ADD     = 16'h0200,
    S_WRX     = 16'h0400,
    S_KEEP    = 16'h0800,
    S_PASS    = 16'h1000,
    S_REJ     = 16'h2000,
    S_OUT_RD  = 16'h4000,
    S_OUT_EM  = 16'h8000
  } state_t;

  state_t st;
  tri_t   trix;
  logic [2:0] k;
  logic       cur;
  logic [IW-1:0] n;
  logic [IW-1:0] m;
  logic [IW-1:0] idx;
  logic [IW-1:0] nm1;
  poly_t pv;
  poly_t nv;
  poly_t rdata;
  poly_t wdata;
  poly_t load_v;
  poly_t mem [2**(PW+1)];
  logic          we;
  logic          re;
  logic [PW:0]   waddr;
  logic [PW:0]   raddr;

  logic signed [DIST_W-1:0] dp;
  logic signed [DIST_W-1:0] dc;
  logic [DIST_W-1:0] a0;
  logic [DIST_W-1:0] a1;
  logic [DIST_W:0]   sum_c;
  logic [NW-1:0]     num;
  logic [DIST_W:0]   sum;
  logic [DIST_W:0]   rem;
  logic [DIST_W+1:0] r2;
  logic              ge;
  logic [FRAC_BITS:0] nlo;
  logic [FRAC_BITS:0] q;
  logic [CW-1:0]      dcnt;
  logic              crossing;
  logic              keep_ok;

  logic [2:0] lc;
  logic signed [DIST_W-1:0] a_op;
  logic signed [DIST_W-1:0] b_op;
  logic signed [DIST_W-1:0] diff;
  logic signed [PRW-1:0]    prod;
  logic signed [PRW-1:0]    prod_sh;
  logic signed [DIST_W-1:0] lerp_res;

  function automatic poly_t mk_poly(input vertex_t v, input logic [1:0] which);
    poly_t p;
    p.x = v.pos_x;
    p.y = v.pos_y;
    p.z = v.pos_z;
    p.w = v.pos_w;
    for (int j = 0; j < 3; j++) begin
      p.b[j] = (2'(j) == which) ? WEIGHT_ONE : 17'd0;
    end
    return p;
  endfunction

  function automatic result_t mk_res(input poly_t p, input logic [1:0] status,
                                     input logic [2:0] mask, input logic last);
    result_t r;
    r.out_x        = p.x;
    r.out_y        = p.y;
    r.out_z        = p.z;
    r.out_w        = p.w;
    r.bary_first   = p.b[0];
    r.bary_second  = p.b[1];
    r.bary_third   = p.b[2];
    r.status       = status;
    r.outside_mask = mask;
    r.last         = last;
    return r;
  endfunction

  assign pop    = (st == S_IDLE) && qstat.valid;
  assign nm1    = n - IW'(1);
  assign load_v = mk_poly(trix.v[idx[1:0]], idx[1:0]);

  // plane distances of the previous and current vertex
  assign dp = plane_dist(pv.x, pv.y, pv.z, pv.w, k);
  assign dc = plane_dist(rdata.x, rdata.y, rdata.z, rdata.w, k);
  assign crossing = ((dp >= 0) != (dc >= 0)) && (m < IW'(MAX_POLY_VERTICES));
  assign keep_ok  = (dc >= 0) && (m < IW'(MAX_POLY_VERTICES));

  // divider set-up: t = (|dp| * 2^F + sum/2) / sum
  assign a0    = dp[DIST_W-1] ? DIST_W'(-dp) : DIST_W'(dp);
  assign a1    = dc[DIST_W-1] ? DIST_W'(-dc) : DIST_W'(dc);
  assign sum_c = {1'b0, a0} + {1'b0, a1};
  assign num   = {1'b0, a0, {FRAC_BITS{1'b0}}} + NW'(sum_c >> 1);
  assign r2    = {rem, nlo[FRAC_BITS]};
  assign ge    = r2 >= {1'b0, sum};

  // interpolation operands
  always_comb begin
    unique case (lc)
      LC_X:    begin a_op = sx(pv.x); b_op = sx(rdata.x); end
      LC_Y:    begin a_op = sx(pv.y); b_op = sx(rdata.y); end
      LC_Z:    begin a_op = sx(pv.z); b_op = sx(rdata.z); end
      LC_W:    begin a_op = sx(pv.w); b_op = sx(rdata.w); end
      LC_B0:   begin a_op = DIST_W'(pv.b[0]); b_op = DIST_W'(rdata.b[0]); end
      LC_B1:   begin a_op = DIST_W'(pv.b[1]); b_op = DIST_W'(rdata.b[1]); end
      LC_B2:   begin a_op = DIST_W'(pv.b[2]); b_op = DIST_W'(rdata.b[2]); end
      default: begin a_op = sx(pv.x); b_op = sx(rdata.x); end
    endcase
  end
  assign diff     = b_op - a_op;
  // round half up, then floor by 2^F
  assign prod_sh  = (prod + HALF) >>> FRAC_BITS;
  assign lerp_res = a_op + prod_sh[DIST_W-1:0];

  // polygon buffer ports
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = rdata;
    unique case (st)
      S_LOAD: begin
        we    = 1'b1;
        waddr = {1'b0, idx[PW-1:0]};
        wdata = load_v;
      end
      S_PREV_RD: begin
        re    = 1'b1;
        raddr = {cur, nm1[PW-1:0]};
      end
      S_CUR_RD, S_OUT_RD: begin
        re    = 1'b1;
        raddr = {cur, idx[PW-1:0]};
      end
      S_WRX: begin
        we      = 1'b1;
        waddr   = {~cur, m[PW-1:0]};
        wdata   = nv;
        wdata.w = forced_w(nv.x, nv.y, nv.z, k);
      end
      S_KEEP: begin
        we    = keep_ok;
        waddr = {~cur, m[PW-1:0]};
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // clipping sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= S_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      unique case (st)
        S_IDLE: begin
          if (qstat.valid) begin
            trix <= tri_in;
            idx  <= '0;
            st   <= (tri_in.mask == 3'd0) ? S_TRIV : S_LOAD;
          end
        end
        S_TRIV: begin
          strobe <= 1'b1;
          result <= mk_res(load_v, ST_KEEP, 3'd0, idx == IW'(2));
          idx    <= idx + IW'(1);
          if (idx == IW'(2)) st <= S_IDLE;
        end
        S_LOAD: begin
          idx <= idx + IW'(1);
          if (idx == IW'(2)) begin
            k   <= PL_NEAR;
            cur <= 1'b0;
            n   <= IW'(3);
            st  <= S_PREV_RD;
          end
        end
        S_PREV_RD: st <= S_PREV_WT;
        S_PREV_WT: begin
          pv  <= rdata;
          idx <= '0;
          m   <= '0;
          st  <= S_CUR_RD;
        end
        S_CUR_RD: st <= S_CUR_EV;
        S_CUR_EV: begin
          if (crossing) begin
            sum  <= sum_c;
            rem  <= {1'b0, num[NW-1:FRAC_BITS+1]};
            nlo  <= num[FRAC_BITS:0];
            dcnt <= '0;
            st   <= S_DIV;
          end else begin
            st <= S_KEEP;
          end
        end
        S_DIV: begin
          rem  <= ge ? DIST_W'(r2 - {1'b0, sum}) + (DIST_W+1)'(0) : r2[DIST_W:0];
          nlo  <= nlo << 1;
          q    <= {q[FRAC_BITS-1:0], ge};
          dcnt <= dcnt + CW'(1);
          if (dcnt == CW'(FRAC_BITS)) begin
            lc <= LC_X;
            st <= S_MUL;
          end
        end
        S_MUL: begin
          prod <= diff * $signed({1'b0, q});
          st   <= S_ADD;
        end
        S_ADD: begin
          unique case (lc)
            LC_X:    nv.x    <= lerp_res[31:0];
            LC_Y:    nv.y    <= lerp_res[31:0];
            LC_Z:    nv.z    <= lerp_res[31:0];
            LC_W:    nv.w    <= lerp_res[31:0];
            LC_B0:   nv.b[0] <= lerp_res[16:0];
            LC_B1:   nv.b[1] <= lerp_res[16:0];
            LC_B2:   nv.b[2] <= lerp_res[16:0];
            default: nv.x    <= lerp_res[31:0];
          endcase
          if (lc == LC_B2) begin
            st <= S_WRX;
          end else begin
            lc <= lc + 3'd1;
            st <= S_MUL;
          end
        end
        S_WRX: begin
          m  <= m + IW'(1);
          st <= S_KEEP;
        end
        S_KEEP: begin
          if (keep_ok) m <= m + IW'(1);
          pv <= rdata;
          if (idx == nm1) begin
            st <= S_PASS;
          end else begin
            idx <= idx + IW'(1);
            st  <= S_CUR_RD;
          end
        end
        S_PASS: begin
          cur <= ~cur;
          n   <= m;
          idx <= '0;
          if (m < IW'(3)) begin
            st <= S_REJ;
          end else if (k == PL_TOP) begin
            st <= S_OUT_RD;
          end else begin
            k  <= k + 3'd1;
            st <= S_PREV_RD;
          end
        end
        S_REJ: begin
          strobe <= 1'b1;
          result <= mk_res('0, ST_REJECT, trix.mask, 1'b1);
          st     <= S_IDLE;
        end
        S_OUT_RD: st <= S_OUT_EM;
        S_OUT_EM: begin
          strobe <= 1'b1;
          result <= mk_res(rdata, ST_CLIP, trix.mask, idx == nm1);
          if (idx == nm1) begin
            st <= S_IDLE;
          end else begin
            idx <= idx + IW'(1);
            st  <= S_OUT_RD;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/homogeneous_triangle_clipper.sv =====
// An unclipped triangle is pushed into the queue with its third vertex, taken by the back end
// and then gives three results on consecutive cycles.
// A clipped triangle is handled by the sequential clipper, which per plane reads and tests
// each polygon vertex and, at a crossing, runs a divider and a lerp of each component.
// Vertices are taken every cycle until the two-triangle queue fills. The receiver
// cannot stall. Synchronous reset clears the vertex count, queue and sequencer.
`default_nettype none
module homogeneous_triangle_clipper
  import htc_pkg::*;
#(
  parameter int FRAC_BITS         = FRAC_BITS_DEF,
  parameter int MAX_POLY_VERTICES = MAX_POLY_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire vertex_t vertex,
  output logic         busy,
  output logic         strobe,
  output result_t      result
);

  qstat_t qstat;
  logic   push;
  logic   pop;
  tri_t   push_data;
  tri_t   pop_data;

  // accept and classify vertices
  htc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .vertex    (vertex),
    .qstat     (qstat),
    .busy      (busy),
    .push      (push),
    .push_data (push_data)
  );

  // hold complete triangles
  htc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .stat      (qstat),
    .pop_data  (pop_data)
  );

  // clip and emit
  htc_back #(
    .FRAC_BITS         (FRAC_BITS),
    .MAX_POLY_VERTICES (MAX_POLY_VERTICES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .qstat  (qstat),
    .tri_in (pop_data),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule
`default_nettype wire
